[rtl/core/double_ended_priority_queue_top_macros.svh]
// ----------------------------------------------------------------------------
// double-ended priority queue assertion macros
// shared concurrent assertion forms, clocked on clk, idle during reset
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_MACROS_SVH

// condition holds at every edge outside reset
`define DEPQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DEPQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/core/depq_pkg.sv]
// ----------------------------------------------------------------------------
// depq_pkg
// widths, codes and shared types of the double-ended priority queue
// ----------------------------------------------------------------------------
package depq_pkg;

	localparam int unsigned CAPACITY = 1024;
	localparam int unsigned ADDR_W   = $clog2(CAPACITY);
	localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
	localparam int unsigned CLIENT_W = 20;
	localparam int unsigned PRIO_W   = 24;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned ST_W     = 2;
	localparam int unsigned ENTRY_W  = PRIO_W + CLIENT_W;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic [OP_W-1:0] OP_INSERT      = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE_HIGH = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE_LOW  = 2'd2;

	localparam logic [ST_W-1:0] ST_REMOVED = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} depq_state_t;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [CLIENT_W-1:0] client_id;
		logic [PRIO_W-1:0]   priority_req;
	} depq_req_t;

	typedef struct packed {
		logic [CLIENT_W-1:0] served_client;
		logic [ST_W-1:0]     status;
	} depq_res_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} depq_stat_t;

endpackage

[rtl/core/depq_intf.sv]
// ----------------------------------------------------------------------------
// depq channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface depq_req_if;
	import depq_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [CLIENT_W-1:0] client_id;
	logic [PRIO_W-1:0]   priority_req;

	modport source (output valid, output opcode, output client_id, output priority_req,
		input ready);
	modport sink (input valid, input opcode, input client_id, input priority_req,
		output ready);
endinterface

interface depq_res_if;
	import depq_pkg::*;

	logic                valid;
	logic                ready;
	logic [CLIENT_W-1:0] served_client;
	logic [ST_W-1:0]     status;

	modport source (output valid, output served_client, output status, input ready);
	modport sink (input valid, input served_client, input status, output ready);
endinterface

[rtl/core/depq_engine.sv]
// ----------------------------------------------------------------------------
// depq_engine
// arrival-ordered entry store with a sequenced scan and compaction unit
// ----------------------------------------------------------------------------
module depq_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  depq_pkg::depq_req_t   req,
	output logic                  res_valid,
	input  logic                  res_ready,
	output depq_pkg::depq_res_t   res,
	output depq_pkg::depq_stat_t  stat
);
	import depq_pkg::*;

	logic [ENTRY_W-1:0] mem [CAPACITY];

	depq_state_t          state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
	logic                 want_high_q, want_high_d;
	logic [ADDR_W-1:0]    best_idx_q, best_idx_d;
	logic [PRIO_W-1:0]    best_prio_q, best_prio_d;
	logic [CLIENT_W-1:0]  best_client_q, best_client_d;
	depq_res_t            res_q, res_d;

	logic                 iss_s1, iss_d;
	logic [ADDR_W-1:0]    idx_s1;
	logic [ENTRY_W-1:0]   rd_data_s1;

	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ENTRY_W-1:0]   wr_data;
	logic [ADDR_W-1:0]    rd_addr;

	logic [PRIO_W-1:0]    rd_prio;
	logic [CLIENT_W-1:0]  rd_client;
	logic                 take;
	logic [ADDR_W-1:0]    best_idx_next;
	logic                 more;

	assign rd_prio   = rd_data_s1[ENTRY_W-1:CLIENT_W];
	assign rd_client = rd_data_s1[CLIENT_W-1:0];
	assign take      = (idx_s1 == '0) ||
		(want_high_q ? (rd_prio >= best_prio_q) : (rd_prio <= best_prio_q));
	assign best_idx_next = take ? idx_s1 : best_idx_q;
	assign more      = (rd_idx_q < count_q);

	// memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
		idx_s1     <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			iss_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			iss_s1  <= iss_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q      <= rd_idx_d;
		want_high_q   <= want_high_d;
		best_idx_q    <= best_idx_d;
		best_prio_q   <= best_prio_d;
		best_client_q <= best_client_d;
		res_q         <= res_d;
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		rd_idx_d      = rd_idx_q;
		want_high_d   = want_high_q;
		best_idx_d    = best_idx_q;
		best_prio_d   = best_prio_q;
		best_client_d = best_client_q;
		res_d         = res_q;
		iss_d         = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = count_q[ADDR_W-1:0];
		wr_data       = {req.priority_req, req.client_id};
		rd_addr       = rd_idx_q[ADDR_W-1:0];
		req_ready     = (state_q == S_IDLE);
		res_valid     = (state_q == S_DONE);

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					priority if (req.opcode == OP_INSERT) begin
						if (count_q >= CAP_CNT) begin
							res_d   = '{served_client: '0, status: ST_FULL};
							state_d = S_DONE;
						end else begin
							wr_en   = 1'b1;
							count_d = count_q + 1'b1;
						end
					end else if (req.opcode == OP_REMOVE_HIGH ||
							req.opcode == OP_REMOVE_LOW) begin
						want_high_d = (req.opcode == OP_REMOVE_HIGH);
						if (count_q == '0) begin
							res_d   = '{served_client: '0, status: ST_EMPTY};
							state_d = S_DONE;
						end else begin
							rd_idx_d = '0;
							state_d  = S_SCAN;
						end
					end
				end
			end
			S_SCAN: begin
				if (more) begin
					iss_d    = 1'b1;
					rd_idx_d = rd_idx_q + 1'b1;
				end
				if (iss_s1) begin
					if (take) begin
						best_idx_d    = idx_s1;
						best_prio_d   = rd_prio;
						best_client_d = rd_client;
					end
					if ({1'b0, idx_s1} == count_q - 1'b1) begin
						rd_idx_d = {1'b0, best_idx_next} + 1'b1;
						state_d  = S_SHIFT;
					end
				end
			end
			S_SHIFT: begin
				if (more) begin
					iss_d    = 1'b1;
					rd_idx_d = rd_idx_q + 1'b1;
				end
				if (iss_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1 - 1'b1;
					wr_data = rd_data_s1;
				end
				if (!more && !iss_s1) begin
					count_d = count_q - 1'b1;
					res_d   = '{served_client: best_client_q, status: ST_REMOVED};
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res        = res_q;
	assign stat.busy  = (state_q != S_IDLE);
	assign stat.count = count_q;

endmodule

[rtl/core/double_ended_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_priority_queue_top
// bounded double-ended priority queue with an iterative scan engine
// ----------------------------------------------------------------------------
// req channel: a word carries opcode, client_id and priority_req; insert,
// remove highest or remove lowest. res channel: a word carries served_client
// and status, one word per removal, per dropped insert and per empty removal.
// a successful insert gives no word; an unused opcode is swallowed.
// an insert is taken while the engine stays idle and does not hold off the next
// request. a dropped insert or a removal from an empty queue sends the engine
// straight to its done state. a removal first scans every stored entry for the
// highest or lowest priority, then shifts the newer entries above the chosen one
// down to close the gap; both steps go through the single read port of the entry
// memory. a word moves from the engine result register to the output register.
// ready is low from the cycle after a removal or a dropped insert is taken
// until its word has left the engine.
// reset clears the fill count and the sequencer; entry memory is not cleared
// and needs no clearing pass.
// a stalled receiver holds the result in the output register; the next request
// is still taken and runs, and only its own result waits for the register.
// ----------------------------------------------------------------------------
`include "double_ended_priority_queue_top_macros.svh"

module double_ended_priority_queue_top (
	input  logic       clk,
	input  logic       arst_n,
	depq_req_if.sink   req,
	depq_res_if.source res
);
	import depq_pkg::*;

	depq_req_t  eng_req;
	depq_res_t  eng_res;
	depq_stat_t stat;
	logic       eng_res_valid;
	logic       eng_res_ready;

	logic       out_valid_q;
	depq_res_t  out_q;

	assign eng_req = '{opcode: req.opcode, client_id: req.client_id,
		priority_req: req.priority_req};

	depq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req       (eng_req),
		.res_valid (eng_res_valid),
		.res_ready (eng_res_ready),
		.res       (eng_res),
		.stat      (stat)
	);

	assign eng_res_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_res_ready) begin
			out_valid_q <= eng_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid && eng_res_ready) begin
			out_q <= eng_res;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.served_client = out_q.served_client;
	assign res.status        = out_q.status;

	`DEPQ_ASSERT_ALWAYS(a_count_bound, stat.count <= CAP_CNT, "fill count beyond capacity")
	`DEPQ_ASSERT_ALWAYS(a_count_step, (stat.count == $past(stat.count)) || (stat.count == $past(stat.count) + 1'b1) || (stat.count == $past(stat.count) - 1'b1), "fill count jumped")
	`DEPQ_ASSERT_IMPL(a_zero_client, res.valid && res.status != ST_REMOVED, res.served_client == '0, "non-removal word carries a client")
	`DEPQ_ASSERT_IMPL(a_busy_ready, stat.busy, !req.ready, "request taken while engine busy")

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the double-ended priority queue: a shadow store
// predicts each served word, random gaps on both channels, full-store corner
// ----------------------------------------------------------------------------
module tb;
	import depq_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	class depq_mirror;
		logic [PRIO_W-1:0]   slot_prio[$];
		logic [CLIENT_W-1:0] slot_client[$];
		depq_res_t           pending_serves[$];
		int                  errors;

		function int pick_victim(bit want_high);
			int best;
			best = 0;
			for (int i = 1; i < slot_prio.size(); i++) begin
				if (want_high ? (slot_prio[i] >= slot_prio[best]) :
						(slot_prio[i] <= slot_prio[best]))
					best = i;
			end
			return best;
		endfunction

		function void take_request(logic [OP_W-1:0] op, logic [CLIENT_W-1:0] id,
				logic [PRIO_W-1:0] prio);
			depq_res_t r;
			int victim;
			case (op)
				OP_INSERT: begin
					if (slot_prio.size() >= CAPACITY) begin
						r.served_client = '0;
						r.status = ST_FULL;
						pending_serves.push_back(r);
					end else begin
						slot_prio.push_back(prio);
						slot_client.push_back(id);
					end
				end
				OP_REMOVE_HIGH, OP_REMOVE_LOW: begin
					if (slot_prio.size() == 0) begin
						r.served_client = '0;
						r.status = ST_EMPTY;
					end else begin
						victim = pick_victim(op == OP_REMOVE_HIGH);
						r.served_client = slot_client[victim];
						r.status = ST_REMOVED;
						slot_prio.delete(victim);
						slot_client.delete(victim);
					end
					pending_serves.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_served(logic [CLIENT_W-1:0] client, logic [ST_W-1:0] status);
			depq_res_t want;
			if (pending_serves.size() == 0) begin
				$display("%0t: unexpected word client %h status %0d", $time, client, status);
				errors++;
			end else begin
				want = pending_serves.pop_front();
				if (client !== want.served_client) begin
					$display("%0t: served_client expected %h got %h", $time,
						want.served_client, client);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, status);
					errors++;
				end
			end
		endfunction

		function int outstanding();
			return pending_serves.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_gaps;
	int   depth_est;

	depq_req_if req_ch ();
	depq_res_if res_ch ();

	depq_mirror mirror = new();

	double_ended_priority_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		res_ch.ready = no_gaps ? 1'b1 : ($urandom_range(99) >= 32);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				mirror.check_served(res_ch.served_client, res_ch.status);
			if (req_ch.valid && req_ch.ready)
				mirror.take_request(req_ch.opcode, req_ch.client_id, req_ch.priority_req);
		end
	end

	function automatic logic [PRIO_W-1:0] rand_prio();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return '0;
		else if (roll < 30)
			return '1;
		else if (roll < 50)
			return PRIO_W'(24'h000100 + $urandom_range(3));
		else
			return PRIO_W'($urandom);
	endfunction

	task automatic send_word(input logic [OP_W-1:0] op, input logic [CLIENT_W-1:0] id,
			input logic [PRIO_W-1:0] prio);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 32) begin
			req_ch.valid = 1'b0;
			req_ch.opcode = OP_W'($urandom);
			req_ch.client_id = CLIENT_W'($urandom);
			req_ch.priority_req = PRIO_W'($urandom);
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.opcode = op;
		req_ch.client_id = id;
		req_ch.priority_req = prio;
		do @(posedge clk); while (!req_ch.ready);
		if (op == OP_INSERT && depth_est < CAPACITY)
			depth_est++;
		else if ((op == OP_REMOVE_HIGH || op == OP_REMOVE_LOW) && depth_est > 0)
			depth_est--;
	endtask

	task automatic wait_all_served();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (mirror.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic directed_words();
		send_word(OP_REMOVE_HIGH, 20'h12345, 24'h654321);
		send_word(OP_REMOVE_LOW, 20'hFFFFF, 24'hFFFFFF);
		send_word(OP_UNUSED, 20'hFFFFF, 24'hFFFFFF);
		send_word(OP_INSERT, 20'h00001, 24'd5);
		send_word(OP_INSERT, 20'h00002, 24'd5);
		send_word(OP_INSERT, 20'h00003, 24'd9);
		send_word(OP_INSERT, 20'h00004, 24'd9);
		send_word(OP_INSERT, 20'h00005, 24'd5);
		send_word(OP_REMOVE_HIGH, '0, '0);
		send_word(OP_REMOVE_LOW, '0, '0);
		send_word(OP_REMOVE_LOW, '0, '0);
		send_word(OP_REMOVE_HIGH, '0, '0);
		send_word(OP_REMOVE_LOW, '0, '0);
		send_word(OP_REMOVE_LOW, '0, '0);
		send_word(OP_INSERT, 20'hFFFFF, 24'hFFFFFF);
		send_word(OP_INSERT, 20'h00000, 24'h000000);
		send_word(OP_INSERT, 20'hABCDE, 24'hFFFFFF);
		send_word(OP_INSERT, 20'h5A5A5, 24'h000000);
		send_word(OP_REMOVE_HIGH, '0, '0);
		send_word(OP_REMOVE_LOW, '0, '0);
		send_word(OP_REMOVE_HIGH, '0, '0);
		send_word(OP_REMOVE_LOW, '0, '0);
		send_word(OP_REMOVE_HIGH, '0, '0);
		wait_all_served();
	endtask

	task automatic random_words(input int count);
		int roll;
		logic [OP_W-1:0] op;
		for (int n = 0; n < count; n++) begin
			no_gaps = (n >= 40 && n < 120);
			if (n % 150 == 149)
				wait_all_served();
			roll = $urandom_range(99);
			if (roll < 4)
				op = OP_UNUSED;
			else if (depth_est == 0 ? roll < 20 : (depth_est > 40 ? roll < 75 : roll < 52))
				op = $urandom_range(1) ? OP_REMOVE_HIGH : OP_REMOVE_LOW;
			else
				op = OP_INSERT;
			send_word(op, CLIENT_W'($urandom), rand_prio());
		end
		no_gaps = 1'b0;
		wait_all_served();
	endtask

	task automatic full_store_words();
		while (depth_est > 0)
			send_word(OP_REMOVE_LOW, CLIENT_W'($urandom), PRIO_W'($urandom));
		for (int i = 0; i < CAPACITY; i++)
			send_word(OP_INSERT, CLIENT_W'($urandom), rand_prio());
		send_word(OP_INSERT, 20'hFFFFF, 24'hFFFFFF);
		send_word(OP_INSERT, 20'h00000, 24'h000000);
		send_word(OP_REMOVE_HIGH, '0, '0);
		send_word(OP_REMOVE_LOW, '0, '0);
		send_word(OP_INSERT, 20'h0F0F0, 24'h800000);
		send_word(OP_INSERT, 20'h00000, 24'h000000);
		send_word(OP_UNUSED, 20'hFFFFF, 24'hFFFFFF);
		send_word(OP_INSERT, 20'hFFFFF, 24'h7FFFFF);
		send_word(OP_REMOVE_LOW, '0, '0);
		send_word(OP_INSERT, 20'h33333, 24'hFFFFFF);
		send_word(OP_REMOVE_HIGH, '0, '0);
		wait_all_served();
	endtask

	initial begin
		arst_n = 1'b0;
		no_gaps = 1'b0;
		depth_est = 0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_INSERT;
		req_ch.client_id = '0;
		req_ch.priority_req = '0;
		res_ch.ready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		directed_words();
		random_words(160);
		full_store_words();
		repeat (50) @(posedge clk);
		if (mirror.errors == 0 && mirror.outstanding() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#6000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
